/* rtl/core/relay_axis_home_and_position_assert.svh */
// Assertion macros shared by the axis controller RTL.
// Used by files that check their own logic; no other dependencies.
`ifndef RELAY_AXIS_HOME_AND_POSITION_ASSERT_SVH
`define RELAY_AXIS_HOME_AND_POSITION_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define RAHP_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Clocked check that also holds during reset.
`define RAHP_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define RAHP_ASSERT(lbl, ck, rs, prop, msg)
`define RAHP_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

/* rtl/core/rahp_pkg.sv */
// Shared types and constants for the relay axis controller.
// No dependencies; imported by every module of the block.
package rahp_pkg;

  // Field widths.
  localparam int POS_BITS  = 14;
  localparam int BAND_BITS = 12;
  localparam int STAT_BITS = 3;
  // Width for the signed stop-band offset before clamping.
  localparam int CALC_BITS = ((POS_BITS > BAND_BITS) ? POS_BITS : BAND_BITS) + 2;

  // Configuration port geometry.
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 4;

  // Register reset values in millivolts.
  localparam logic [POS_BITS-1:0]  MIN_MV_RST   = POS_BITS'(290);
  localparam logic [POS_BITS-1:0]  MAX_MV_RST   = POS_BITS'(8550);
  localparam logic [BAND_BITS-1:0] BAND_IN_RST  = BAND_BITS'(200);
  localparam logic [BAND_BITS-1:0] BAND_OUT_RST = BAND_BITS'(200);

  typedef logic [POS_BITS-1:0]  pos_t;
  typedef logic [BAND_BITS-1:0] band_t;
  typedef logic signed [CALC_BITS-1:0] calc_t;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_HOME = 2'd1,
    KIND_MOVE = 2'd2,
    KIND_HALT = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [STAT_BITS-1:0] {
    ST_OK    = 3'd0,
    ST_RUN   = 3'd1,
    ST_PAUSE = 3'd2,
    ST_STOP  = 3'd3,
    ST_ERR   = 3'd4
  } status_t;

  // Live configuration.
  typedef struct packed {
    pos_t  min_mv;
    pos_t  max_mv;
    band_t band_in_mv;
    band_t band_out_mv;
  } cfg_t;

  // One registered request.
  typedef struct packed {
    kind_t kind;
    pos_t  target_mv;
    pos_t  sample_mv;
    logic  sample_ok;
    logic  home_seen;
    logic  pause_req;
    logic  stop_req;
  } cmd_t;

  // Control part of one result.
  typedef struct packed {
    status_t status;
    logic    relay_on;
    logic    relay_up;
    logic    is_homed;
  } res_t;

endpackage

/* rtl/core/relay_axis_home_and_position.sv */
// Relay axis controller top level: input register, decision logic, result register.
// A request accepted into the input register passes to the result register when that register is free.
// Throughput: one request per cycle while the result channel does not stall; set by the single pass through rahp_ctrl.
// Reset (rst, synchronous): axis idle and not homed, configuration registers at their defaults.
// Depends on rahp_pkg, rahp_cfg and rahp_ctrl.
module relay_axis_home_and_position
  import rahp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Request channel.
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  logic [1:0]           kind,
  input  logic [POS_BITS-1:0]  target_mv,
  input  logic [POS_BITS-1:0]  sample_mv,
  input  logic                 sample_ok,
  input  logic                 home_seen,
  input  logic                 pause_req,
  input  logic                 stop_req,
  // Result channel.
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [STAT_BITS-1:0] status,
  output logic                 relay_on,
  output logic                 relay_up,
  output logic [POS_BITS-1:0]  pos_mv,
  output logic                 pos_ok,
  output logic                 is_homed,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  cfg_t cfg;
  cmd_t cmd_q;
  logic cmd_v;
  res_t res_c;
  res_t res_q;
  pos_t pos_q;
  logic pos_ok_q;
  logic adv;
  logic cmd_take;

  rahp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rahp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .cmd (cmd_q),
    .cfg (cfg),
    .res (res_c)
  );

  // The request in the input register moves on when the result register is free.
  assign adv       = cmd_v && (!res_valid || !res_stall);
  assign cmd_stall = cmd_v && !adv;
  assign cmd_take  = cmd_valid && !cmd_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_v <= 1'b0;
    end else if (cmd_take) begin
      cmd_v <= 1'b1;
    end else if (adv) begin
      cmd_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q.kind      <= kind_t'(kind);
      cmd_q.target_mv <= target_mv;
      cmd_q.sample_mv <= sample_mv;
      cmd_q.sample_ok <= sample_ok;
      cmd_q.home_seen <= home_seen;
      cmd_q.pause_req <= pause_req;
      cmd_q.stop_req  <= stop_req;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q    <= res_c;
      pos_q    <= cmd_q.sample_ok ? cmd_q.sample_mv : '0;
      pos_ok_q <= cmd_q.sample_ok;
    end
  end

  assign status   = res_q.status;
  assign relay_on = res_q.relay_on;
  assign relay_up = res_q.relay_up;
  assign is_homed = res_q.is_homed;
  assign pos_mv   = pos_q;
  assign pos_ok   = pos_ok_q;

endmodule

/* rtl/core/rahp_cfg.sv */
// APB-style register file holding the position limits and stop bands.
// Depends on rahp_pkg.
module rahp_cfg
  import rahp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  // Register indexes, taken from the word address.
  localparam logic [1:0] REG_MIN      = 2'd0;
  localparam logic [1:0] REG_MAX      = 2'd1;
  localparam logic [1:0] REG_BAND_IN  = 2'd2;
  localparam logic [1:0] REG_BAND_OUT = 2'd3;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_mv      <= MIN_MV_RST;
      cfg.max_mv      <= MAX_MV_RST;
      cfg.band_in_mv  <= BAND_IN_RST;
      cfg.band_out_mv <= BAND_OUT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MIN:      cfg.min_mv      <= pwdata[POS_BITS-1:0];
        REG_MAX:      cfg.max_mv      <= pwdata[POS_BITS-1:0];
        REG_BAND_IN:  cfg.band_in_mv  <= pwdata[BAND_BITS-1:0];
        REG_BAND_OUT: cfg.band_out_mv <= pwdata[BAND_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    case (reg_idx)
      REG_MIN:      prdata = DATA_BITS'(cfg.min_mv);
      REG_MAX:      prdata = DATA_BITS'(cfg.max_mv);
      REG_BAND_IN:  prdata = DATA_BITS'(cfg.band_in_mv);
      REG_BAND_OUT: prdata = DATA_BITS'(cfg.band_out_mv);
      default:      prdata = '0;
    endcase
  end

endmodule

/* rtl/core/rahp_ctrl.sv */
// Axis state and the single-pass decision logic for one request.
// Depends on rahp_pkg and the shared assertion macro header.
`include "relay_axis_home_and_position_assert.svh"

module rahp_ctrl
  import rahp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output res_t res
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HOMING = 2'd1,
    MODE_MOVING = 2'd2
  } mode_t;

  mode_t   mode, mode_next;
  pos_t    goal_mv, goal_mv_next;
  logic    going_up, going_up_next;
  logic    homed_flag, homed_flag_next;
  status_t status;

  calc_t tgt_c, smp_c, min_c, max_c, comp_raw, comp_lo, comp;
  logic  move_up, move_bad, move_done, tick_done;

  // Offset goal for a move: pick direction, apply the stop band, clamp.
  always_comb begin
    tgt_c    = calc_t'(cmd.target_mv);
    smp_c    = calc_t'(cmd.sample_mv);
    min_c    = calc_t'(cfg.min_mv);
    max_c    = calc_t'(cfg.max_mv);
    move_up  = cmd.sample_mv < cmd.target_mv;
    comp_raw = move_up ? tgt_c - calc_t'(cfg.band_out_mv)
                       : tgt_c + calc_t'(cfg.band_in_mv);
    comp_lo  = (comp_raw < min_c) ? min_c : comp_raw;
    comp     = (comp_lo > max_c) ? max_c : comp_lo;
    move_done = move_up ? (smp_c >= comp) : (smp_c <= comp);
    move_bad  = !homed_flag || (cmd.target_mv < cfg.min_mv) ||
                (cmd.target_mv > cfg.max_mv) || !cmd.sample_ok;
    tick_done = going_up ? (cmd.sample_mv >= goal_mv) : (cmd.sample_mv <= goal_mv);
  end

  // Next state and status for the request in the input register.
  always_comb begin
    mode_next       = mode;
    goal_mv_next    = goal_mv;
    going_up_next   = going_up;
    homed_flag_next = homed_flag;
    status          = ST_OK;
    case (cmd.kind)
      KIND_TICK: begin
        case (mode)
          MODE_HOMING: begin
            if (cmd.pause_req) begin
              mode_next = MODE_IDLE;
              status    = ST_PAUSE;
            end else if (cmd.stop_req) begin
              mode_next = MODE_IDLE;
              status    = ST_STOP;
            end else if (cmd.home_seen) begin
              homed_flag_next = 1'b1;
              mode_next       = MODE_IDLE;
              status          = ST_OK;
            end else begin
              status = ST_RUN;
            end
          end
          MODE_MOVING: begin
            if (cmd.stop_req) begin
              mode_next = MODE_IDLE;
              status    = ST_STOP;
            end else if (cmd.pause_req) begin
              mode_next = MODE_IDLE;
              status    = ST_PAUSE;
            end else if (!cmd.sample_ok) begin
              mode_next = MODE_IDLE;
              status    = ST_ERR;
            end else if (tick_done) begin
              mode_next = MODE_IDLE;
              status    = ST_OK;
            end else begin
              status = ST_RUN;
            end
          end
          default: begin
            mode_next = MODE_IDLE;
            status    = ST_OK;
          end
        endcase
      end
      KIND_HOME: begin
        if (cmd.home_seen) begin
          homed_flag_next = 1'b1;
          mode_next       = MODE_IDLE;
          status          = ST_OK;
        end else begin
          mode_next = MODE_HOMING;
          status    = ST_RUN;
        end
      end
      KIND_MOVE: begin
        if (move_bad) begin
          status = ST_ERR;
        end else if (move_done) begin
          mode_next = MODE_IDLE;
          status    = ST_OK;
        end else begin
          mode_next     = MODE_MOVING;
          goal_mv_next  = comp[POS_BITS-1:0];
          going_up_next = move_up;
          status        = ST_RUN;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        status    = ST_OK;
      end
    endcase
  end

  // Result fields that follow from the new state.
  always_comb begin
    res.status   = status;
    res.relay_on = (mode_next != MODE_IDLE);
    res.relay_up = (mode_next == MODE_MOVING) ? going_up_next : 1'b0;
    res.is_homed = homed_flag_next;
  end

  // Axis state, updated when a request passes to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      goal_mv    <= '0;
      going_up   <= 1'b0;
      homed_flag <= 1'b0;
    end else if (adv) begin
      mode       <= mode_next;
      goal_mv    <= goal_mv_next;
      going_up   <= going_up_next;
      homed_flag <= homed_flag_next;
    end
  end

  `RAHP_ASSERT(a_homed_sticky, clk, rst, homed_flag |=> homed_flag, "homed flag was lost")
  `RAHP_ASSERT(a_move_needs_home, clk, rst, (mode == MODE_MOVING) |-> homed_flag, "moving while not homed")
  `RAHP_ASSERT(a_halt_idles, clk, rst, (adv && cmd.kind == KIND_HALT) |=> (mode == MODE_IDLE), "halt left axis active")
  `RAHP_ASSERT(a_hold_state, clk, rst, !adv |=> ($stable(mode) && $stable(goal_mv)), "state changed without a request")

endmodule
